// ===== src/bls_pkg.sv =====
// bls_pkg: word types, opcodes and controller states for block_lower_bound_scan
// no dependencies; used by block_lower_bound_scan and bls_row_match
package bls_pkg;

	localparam int POS_W   = 7;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 8;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic               op;
		logic [POS_W-1:0]   position;
		logic [DATA_W-1:0]  value;
		logic               descending;
		logic [COUNT_W-1:0] entry_count;
	} cmd_word_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] hit_index;
	} result_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN
	} state_t;

endpackage

// ===== src/block_lower_bound_scan.sv =====
// block_lower_bound_scan: sorted entry block with lane-parallel lower-bound search
// depends on bls_pkg, bls_ram, bls_row_match
//
//  channel  | signals             | handshake
//  ---------+---------------------+-----------------------------------------
//  command  | cmd (cmd_word_t)    | taken at clk edge with start && !busy
//  result   | result (result_word_t) | valid for one cycle while done is high
//
// entries sit in rows of a power-of-two lane count (LANES rounded up) in one ram.
// a write is a row read, then a merged row write-back.
// a search reads one row per cycle, at most ROWS (8 by default), from the start row
// to the first hit row or last row below count; start at or past count reads none.
// reset clears the controller only; the ram holds garbage until written.
// results cannot be held off; busy is high only in the write-back and scan states.
module block_lower_bound_scan #(
	parameter int BLOCK_SIZE = 128,
	parameter int LANES      = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  bls_pkg::cmd_word_t    cmd,
	output logic                  done,
	output bls_pkg::result_word_t result
);

	localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int ROW_LANES = 2 ** LANE_W;
	localparam int ROWS      = (BLOCK_SIZE + ROW_LANES - 1) / ROW_LANES;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RAM_DEPTH = 2 ** ROW_W;
	localparam int PW        = ROW_W + LANE_W;
	localparam int CW        = (PW + 1 > bls_pkg::COUNT_W) ? PW + 1 : bls_pkg::COUNT_W;
	localparam int ROW_BITS  = ROW_LANES * bls_pkg::DATA_W;

	bls_pkg::state_t state_q, state_d;

	logic [CW-1:0]     pos_ext, cnt_ext, cnt_sat;
	logic [ROW_W-1:0]  in_row;
	logic [LANE_W-1:0] in_lane;
	logic              accept, wr_ok, empty;

	logic [ROW_W-1:0]           row_q;
	logic [LANE_W-1:0]          lane_q;
	logic [bls_pkg::DATA_W-1:0] value_q;
	logic                       desc_q;
	logic [CW-1:0]              start_q, cnt_q;

	logic             valid_s1;
	logic [ROW_W-1:0] row_s1;

	logic                done_q;
	bls_pkg::result_word_t result_q;

	logic                rd_en, we, scan_rd;
	logic [ROW_W-1:0]    rd_addr;
	logic [ROW_BITS-1:0] rd_data, wr_data;

	logic              row_hit, last_row, scan_done;
	logic [LANE_W-1:0] hit_lane;
	logic [CW-1:0]     row_base, next_base, hit_idx;

	assign pos_ext = CW'(cmd.position);
	assign cnt_ext = CW'(cmd.entry_count);
	assign cnt_sat = (cnt_ext > CW'(BLOCK_SIZE)) ? CW'(BLOCK_SIZE) : cnt_ext;
	assign in_row  = pos_ext[LANE_W +: ROW_W];
	assign in_lane = pos_ext[LANE_W-1:0];
	assign wr_ok   = pos_ext < CW'(BLOCK_SIZE);
	assign empty   = pos_ext >= cnt_sat;
	assign accept  = start && (state_q == bls_pkg::ST_IDLE);

	assign row_base  = CW'({row_s1, {LANE_W{1'b0}}});
	assign next_base = row_base + CW'(ROW_LANES);
	assign last_row  = next_base >= cnt_q;
	assign scan_done = valid_s1 && (row_hit || last_row);
	assign hit_idx   = row_base | CW'(hit_lane);

	bls_row_match #(
		.ROW_LANES (ROW_LANES),
		.IDX_W     (CW)
	) u_match (
		.row_data   (rd_data),
		.pivot      (value_q),
		.descending (desc_q),
		.row_base   (row_base),
		.start_idx  (start_q),
		.count      (cnt_q),
		.hit        (row_hit),
		.lane       (hit_lane)
	);

	always_comb begin
		wr_data = rd_data;
		wr_data[lane_q*bls_pkg::DATA_W +: bls_pkg::DATA_W] = value_q;
	end

	bls_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.wr_addr (row_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bls_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.op == bls_pkg::OP_WRITE) begin
						state_d = wr_ok ? bls_pkg::ST_WRITE : bls_pkg::ST_IDLE;
					end else begin
						state_d = empty ? bls_pkg::ST_IDLE : bls_pkg::ST_SCAN;
					end
				end
			end
			bls_pkg::ST_WRITE: begin
				state_d = bls_pkg::ST_IDLE;
			end
			bls_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = bls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bls_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy    = 1'b1;
		rd_en   = 1'b0;
		rd_addr = row_q;
		scan_rd = 1'b0;
		we      = 1'b0;
		case (state_q)
			bls_pkg::ST_IDLE: begin
				busy    = 1'b0;
				rd_addr = in_row;
				if (accept) begin
					if (cmd.op == bls_pkg::OP_WRITE) begin
						rd_en = wr_ok;
					end else begin
						rd_en   = !empty;
						scan_rd = !empty;
					end
				end
			end
			bls_pkg::ST_WRITE: begin
				we = 1'b1;
			end
			bls_pkg::ST_SCAN: begin
				rd_en   = !scan_done;
				scan_rd = !scan_done;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bls_pkg::ST_IDLE;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= scan_rd;
			done_q   <= scan_done || (accept && (cmd.op == bls_pkg::OP_SEARCH) && empty);
			if (scan_done && row_hit) begin
				result_q.hit       <= 1'b1;
				result_q.hit_index <= hit_idx[bls_pkg::POS_W-1:0];
			end else begin
				result_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= rd_addr;
		if (accept) begin
			value_q <= cmd.value;
			desc_q  <= cmd.descending;
			start_q <= pos_ext;
			cnt_q   <= cnt_sat;
			lane_q  <= in_lane;
			row_q   <= (cmd.op == bls_pkg::OP_WRITE) ? in_row : in_row + ROW_W'(1);
		end else if (scan_rd) begin
			row_q <= row_q + ROW_W'(1);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == bls_pkg::ST_SCAN)
			|| $past(start && !busy && (cmd.op == bls_pkg::OP_SEARCH)))
		else $error("result word without a search");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.hit_index == '0))
		else $error("miss word carries a nonzero index");

	a_write_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bls_pkg::ST_WRITE) |=> (state_q == bls_pkg::ST_IDLE) && !done)
		else $error("write did not finish in two cycles");

	a_scan_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ($past(state_q) == bls_pkg::ST_SCAN) || $past(start && !busy))
		else $error("row compare without an issued scan read");

endmodule

// ===== src/bls_ram.sv =====
// bls_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module bls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/bls_row_match.sv =====
// bls_row_match: compares one memory row against the pivot inside [start, count)
// depends on bls_pkg; reports the lowest qualifying lane
module bls_row_match #(
	parameter int ROW_LANES = 16,
	parameter int IDX_W     = 8
) (
	input  logic [ROW_LANES*bls_pkg::DATA_W-1:0]              row_data,
	input  logic [bls_pkg::DATA_W-1:0]                        pivot,
	input  logic                                              descending,
	input  logic [IDX_W-1:0]                                  row_base,
	input  logic [IDX_W-1:0]                                  start_idx,
	input  logic [IDX_W-1:0]                                  count,
	output logic                                              hit,
	output logic [((ROW_LANES > 1) ? $clog2(ROW_LANES) : 1)-1:0] lane
);

	localparam int LW = (ROW_LANES > 1) ? $clog2(ROW_LANES) : 1;

	logic [ROW_LANES-1:0] qual;

	always_comb begin
		logic [IDX_W-1:0]           p;
		logic [bls_pkg::DATA_W-1:0] ent;
		for (int l = 0; l < ROW_LANES; l++) begin
			p   = row_base + IDX_W'(l);
			ent = row_data[l*bls_pkg::DATA_W +: bls_pkg::DATA_W];
			qual[l] = (p >= start_idx) && (p < count)
				&& (descending ? (ent <= pivot) : (ent >= pivot));
		end
	end

	always_comb begin
		hit  = |qual;
		lane = '0;
		for (int l = ROW_LANES - 1; l >= 0; l--) begin
			if (qual[l]) begin
				lane = LW'(l);
			end
		end
	end

endmodule
